// ===== rtl/lppd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ARMED  = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hDF;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hFD;

  typedef struct packed {
    logic [BYTE_W-1:0] pkt_byte;
    logic              pkt_first;
    logic              pkt_last;
  } pkt_t;

endpackage

// ===== rtl/lppd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd channel interfaces
// Valid/ready channels for received bytes and for packet bytes.
// ----------------------------------------------------------------------------
interface lppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lppd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       pkt_first;
  logic       pkt_last;

  modport source (output valid, output pkt_byte, output pkt_first, output pkt_last,
                  input ready);
  modport sink (input valid, input pkt_byte, input pkt_first, input pkt_last,
                output ready);
endinterface

// ===== rtl/lppd_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_in_reg
// Input register holding one received byte until the core takes it.
// ----------------------------------------------------------------------------
module lppd_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lppd_pkg::BYTE_W-1:0] in_byte,
  input  logic                      pop,
  output logic                      stg_valid,
  output logic [lppd_pkg::BYTE_W-1:0] stg_byte
);
  import lppd_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  assign in_ready  = !valid_r || pop;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !pop);
  assign stg_valid = valid_r;
  assign stg_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== rtl/lppd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_core
// Sync header hunt, length capture and body count; holds the sync registers.
// ----------------------------------------------------------------------------
module lppd_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lppd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lppd_pkg::BYTE_W-1:0]  cfg_wdata,
  input  logic                         stg_valid,
  input  logic [lppd_pkg::BYTE_W-1:0]  stg_byte,
  input  logic                         out_free,
  output logic                         pop,
  output logic                         res_valid,
  output lppd_pkg::pkt_t               res
);
  import lppd_pkg::*;

  logic [BYTE_W-1:0] sync_first_r;
  logic [BYTE_W-1:0] sync_second_r;
  logic [1:0]        phase_r;
  logic [1:0]        phase_nxt;
  logic [LEN_W-1:0]  left_r;
  logic [LEN_W-1:0]  left_nxt;
  logic [LEN_W-1:0]  left_dec;

  assign pop      = stg_valid && out_free;
  assign left_dec = left_r - LEN_W'(1);

  always_comb begin
    phase_nxt     = phase_r;
    left_nxt      = left_r;
    res_valid     = 1'b0;
    res.pkt_byte  = stg_byte;
    res.pkt_first = 1'b0;
    res.pkt_last  = 1'b0;
    case (phase_r)
      PH_ARMED: begin
        if (stg_byte == sync_second_r) begin
          phase_nxt = PH_LENGTH;
        end else if (stg_byte == sync_first_r) begin
          phase_nxt = PH_ARMED;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_LENGTH: begin
        left_nxt      = {1'b0, stg_byte} + LEN_W'(1);
        phase_nxt     = PH_BODY;
        res_valid     = pop;
        res.pkt_first = 1'b1;
      end
      PH_BODY: begin
        left_nxt     = left_dec;
        res_valid    = pop;
        res.pkt_last = (left_dec == '0);
        if (left_dec == '0) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = (stg_byte == sync_first_r) ? PH_ARMED : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      left_r  <= '0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lppd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_out_reg
// Result register presenting one packet byte to the downstream sink.
// ----------------------------------------------------------------------------
module lppd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  lppd_pkg::pkt_t res,
  output logic           out_free,
  output logic           out_valid,
  input  logic           out_ready,
  output lppd_pkg::pkt_t out_pkt
);
  import lppd_pkg::*;

  logic valid_r;
  logic valid_nxt;
  pkt_t pkt_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = res_valid || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_pkt   = pkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      pkt_r <= res;
    end
  end

endmodule

// ===== rtl/length_prefixed_packet_deframer.sv =====
`timescale 1ns / 1ps
// path: each accepted byte passes the input register, then the result register
// throughput: one byte per cycle, set by the single input and result registers, unless the sink stalls
// header bytes give no item; the length byte and each body byte give one item
// reset (rst_n, synchronous): hunt restarts idle, both registers empty,
// sync bytes return to 0xDF and 0xFD
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Finds a two-byte sync header and passes on the length byte and body bytes.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  lppd_in_if.sink                      in_ch,
  lppd_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [lppd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lppd_pkg::BYTE_W-1:0]  cfg_wdata
);
  import lppd_pkg::*;

  logic              stg_valid;
  logic [BYTE_W-1:0] stg_byte;
  logic              pop;
  logic              out_free;
  logic              res_valid;
  pkt_t              res;
  pkt_t              out_pkt;

  lppd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.rx_byte),
    .pop       (pop),
    .stg_valid (stg_valid),
    .stg_byte  (stg_byte)
  );

  lppd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .stg_valid (stg_valid),
    .stg_byte  (stg_byte),
    .out_free  (out_free),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  lppd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pkt   (out_pkt)
  );

  assign out_ch.pkt_byte  = out_pkt.pkt_byte;
  assign out_ch.pkt_first = out_pkt.pkt_first;
  assign out_ch.pkt_last  = out_pkt.pkt_last;

endmodule
